// ===== src/bpfa_pkg.sv =====
`default_nettype none
package bpfa_pkg;
	localparam int MAX_FRAMES_DEF = 65536;
	localparam int PAGE_BYTES_DEF = 4096;
	localparam int ADDR_W = 36;
	localparam int CNT_W = 17;
	localparam int OP_W = 3;
	localparam int ST_W = 3;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 3'd0,
		OP_FREE1 = 3'd1,
		OP_FREER = 3'd2,
		OP_RSV = 3'd3,
		OP_UNRSV = 3'd4,
		OP_RECOUNT = 3'd5
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK = 3'd0,
		ST_OOM = 3'd1,
		ST_INVAL = 3'd2,
		ST_OOB = 3'd3,
		ST_DFREE = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PREP, S_SUM, S_CLAMP, S_SCAN_RD, S_SCAN_BITS,
		S_MARK, S_MOD_RD, S_MOD_WR, S_DONE
	} state_t;

	typedef struct packed {
		logic clr;
		logic take;
		logic prep;
		logic sum;
		logic clamp;
		logic scan_rd;
		logic scan_bits;
		logic mark;
		logic mod_rd;
		logic mod_wr;
		logic done;
	} cmd_t;

	typedef struct packed {
		logic in_fire;
		logic clr_last;
		logic go_scan;
		logic go_mod;
		logic scan_hit;
		logic sub_last;
		logic word_last;
		logic mod_last;
		logic out_busy;
	} stat_t;

	function automatic logic [6:0] popcnt64(input logic [63:0] v);
		logic [3:0] b [8];
		logic [6:0] s;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			b[i] = 4'(v[8*i]) + 4'(v[8*i+1]) + 4'(v[8*i+2]) + 4'(v[8*i+3])
				+ 4'(v[8*i+4]) + 4'(v[8*i+5]) + 4'(v[8*i+6]) + 4'(v[8*i+7]);
		end
		for (int i = 0; i < 8; i++) begin
			s = s + 7'(b[i]);
		end
		return s;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c,
		input logic [6:0] n);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(c) + (CNT_W+1)'(n);
		return (s > (CNT_W+1)'(CNT_MAX)) ? CNT_MAX : CNT_W'(s);
	endfunction

	function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] c,
		input logic [6:0] n);
		return (c > CNT_W'(n)) ? c - CNT_W'(n) : '0;
	endfunction
endpackage
`default_nettype wire

// ===== src/bpfa_if.sv =====
`default_nettype none
interface bpfa_cmd_if;
	import bpfa_pkg::*;
	logic valid;
	logic ready;
	logic [OP_W-1:0] op;
	logic [ADDR_W-1:0] byte_address;
	logic [CNT_W-1:0] page_count;
	logic [ADDR_W-1:0] region_bytes;
	modport source (output valid, op, byte_address, page_count, region_bytes, input ready);
	modport sink (input valid, op, byte_address, page_count, region_bytes, output ready);
endinterface

interface bpfa_rsp_if;
	import bpfa_pkg::*;
	logic valid;
	logic ready;
	logic [ST_W-1:0] status;
	logic [ADDR_W-1:0] alloc_address;
	logic [CNT_W-1:0] free_count;
	logic [CNT_W-1:0] used_count;
	logic [CNT_W-1:0] reserved_count;
	logic [ADDR_W-1:0] last_alloc_address;
	logic [ADDR_W-1:0] last_free_address;
	modport source (output valid, status, alloc_address, free_count, used_count,
		reserved_count, last_alloc_address, last_free_address, input ready);
	modport sink (input valid, status, alloc_address, free_count, used_count,
		reserved_count, last_alloc_address, last_free_address, output ready);
endinterface
`default_nettype wire

// ===== src/bpfa_ram.sv =====
`default_nettype none
module bpfa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== src/bpfa_ctrl.sv =====
`default_nettype none
module bpfa_ctrl import bpfa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire stat_t stat,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (stat.clr_last) state_d = S_IDLE;
			S_IDLE: if (stat.in_fire) state_d = S_PREP;
			S_PREP: state_d = S_SUM;
			S_SUM: state_d = S_CLAMP;
			S_CLAMP: begin
				if (stat.go_scan) state_d = S_SCAN_RD;
				else if (stat.go_mod) state_d = S_MARK;
				else state_d = S_DONE;
			end
			S_SCAN_RD: state_d = S_SCAN_BITS;
			S_SCAN_BITS: begin
				if (stat.scan_hit) state_d = S_MARK;
				else if (stat.sub_last && stat.word_last) state_d = S_DONE;
				else if (stat.sub_last) state_d = S_SCAN_RD;
			end
			S_MARK: state_d = S_MOD_RD;
			S_MOD_RD: state_d = S_MOD_WR;
			S_MOD_WR: state_d = stat.mod_last ? S_DONE : S_MOD_RD;
			S_DONE: if (!stat.out_busy) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLEAR: cmd.clr = 1'b1;
			S_IDLE: cmd.take = 1'b1;
			S_PREP: cmd.prep = 1'b1;
			S_SUM: cmd.sum = 1'b1;
			S_CLAMP: cmd.clamp = 1'b1;
			S_SCAN_RD: cmd.scan_rd = 1'b1;
			S_SCAN_BITS: cmd.scan_bits = 1'b1;
			S_MARK: cmd.mark = 1'b1;
			S_MOD_RD: cmd.mod_rd = 1'b1;
			S_MOD_WR: cmd.mod_wr = 1'b1;
			S_DONE: cmd.done = 1'b1;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/bpfa_dp.sv =====
`default_nettype none
module bpfa_dp import bpfa_pkg::*; #(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cmd_t cmd,
	output stat_t stat,
	bpfa_cmd_if.sink cin,
	bpfa_rsp_if.source rsp,
	input wire logic cfg_we,
	input wire logic [CNT_W-1:0] cfg_wdata
);
	localparam int FW = $clog2(MAX_FRAMES) + 1;
	localparam int WORDS = MAX_FRAMES / 64;
	localparam int WAW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SH = $clog2(PAGE_BYTES);
	localparam int WW = ADDR_W + 2;
	localparam logic [CNT_W-1:0] RSV_RST =
		(MAX_FRAMES > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(MAX_FRAMES);

	logic [CNT_W-1:0] fiu_q;
	logic [FW-1:0] total;
	logic [OP_W-1:0] op_q;
	logic [ADDR_W-1:0] addr_q, len_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WW-1:0] start_q, n_q, end_q;
	logic [FW-1:0] lo_q, hi_q, run_start_q, acc_q;
	logic [CNT_W-1:0] run_q;
	logic [WAW-1:0] w_q, clr_q;
	logic [2:0] sub_q;
	logic [ST_W-1:0] status_q;
	logic [CNT_W-1:0] free_q, used_q, rsv_q;
	logic [ADDR_W-1:0] last_alloc_q, last_free_q;
	logic out_valid_q;
	logic [63:0] rdata;

	assign total = (32'(fiu_q) > 32'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : FW'(fiu_q);
	assign cin.ready = cmd.take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= CNT_W'(65536);
		end else if (cfg_we) begin
			fiu_q <= cfg_wdata;
		end
	end

	// decisions at clamp time
	logic misal, inval_addr;
	logic [FW-1:0] lo_c, hi_c;
	logic empty_c;
	assign misal = |addr_q[SH-1:0];
	assign inval_addr = (addr_q == '0) || misal;
	always_comb begin
		lo_c = (start_q >= WW'(total)) ? total : FW'(start_q);
		hi_c = (end_q > WW'(total)) ? total : FW'(end_q);
		if (op_q == OP_RECOUNT) begin
			lo_c = '0;
			hi_c = total;
		end
	end
	assign empty_c = lo_c >= hi_c;

	logic go_scan, go_mod;
	logic [ST_W-1:0] st_c;
	always_comb begin
		go_scan = 1'b0;
		go_mod = 1'b0;
		st_c = ST_OK;
		case (op_q)
			OP_ALLOC: begin
				if (cnt_q == '0) st_c = ST_INVAL;
				else begin
					st_c = ST_OOM;
					go_scan = total != '0;
				end
			end
			OP_FREE1: begin
				if (inval_addr) st_c = ST_INVAL;
				else if (start_q >= WW'(total)) st_c = ST_OOB;
				else go_mod = 1'b1;
			end
			OP_FREER: begin
				if (inval_addr || cnt_q == '0) st_c = ST_INVAL;
				else go_mod = !empty_c;
			end
			OP_RSV, OP_UNRSV, OP_RECOUNT: go_mod = !empty_c;
			default: st_c = ST_INVAL;
		endcase
	end

	// first-fit search, eight frames per step
	logic [CNT_W-1:0] run_c;
	logic [FW-1:0] rs_c, re_c, f;
	logic hit_c, u;
	logic [FW-1:0] tm1;
	assign tm1 = total - FW'(1);
	always_comb begin
		run_c = run_q;
		rs_c = run_start_q;
		re_c = '0;
		hit_c = 1'b0;
		f = '0;
		u = 1'b0;
		for (int b = 0; b < 8; b++) begin
			f = FW'({w_q, sub_q, 3'(b)});
			u = rdata[{sub_q, 3'(b)}] | (f >= total);
			if (!hit_c) begin
				if (u) run_c = '0;
				else begin
					if (run_c == '0) rs_c = f;
					run_c = run_c + CNT_W'(1);
					if (run_c == cnt_q) begin
						hit_c = 1'b1;
						re_c = f + FW'(1);
					end
				end
			end
		end
	end

	// word update for range passes
	logic [FW-1:0] hm1;
	logic [WAW-1:0] lo_w, last_w;
	logic [63:0] mask, nword, chg;
	logic [6:0] pc;
	logic set_op;
	assign hm1 = hi_q - FW'(1);
	assign lo_w = lo_q[WAW+5:6];
	assign last_w = hm1[WAW+5:6];
	assign set_op = (op_q == OP_ALLOC) || (op_q == OP_RSV);
	always_comb begin
		mask = '1;
		if (w_q == lo_w) mask = mask & ({64{1'b1}} << lo_q[5:0]);
		if (w_q == last_w) mask = mask & ({64{1'b1}} >> (6'd63 - hm1[5:0]));
		if (op_q == OP_RECOUNT) chg = rdata & mask;
		else if (set_op) chg = mask & ~rdata;
		else chg = mask & rdata;
		nword = set_op ? (rdata | mask) : (rdata & ~mask);
	end
	assign pc = popcnt64(chg);

	bpfa_ram #(.WIDTH(64), .DEPTH(WORDS)) u_bits (
		.clk(clk),
		.we(cmd.clr || (cmd.mod_wr && op_q != OP_RECOUNT)),
		.waddr(cmd.clr ? clr_q : w_q),
		.wdata(cmd.clr ? {64{1'b1}} : nword),
		.re(cmd.scan_rd || cmd.mod_rd),
		.raddr(w_q),
		.rdata(rdata)
	);

	// final values
	logic load_out, is_ok;
	logic [CNT_W-1:0] fin_free, fin_used;
	logic [ADDR_W-1:0] got;
	logic [FW-1:0] rc_free;
	assign load_out = cmd.done && !stat.out_busy;
	assign is_ok = status_q == ST_OK;
	assign rc_free = total - acc_q;
	assign got = (op_q == OP_ALLOC && is_ok) ? ADDR_W'({lo_q, {SH{1'b0}}}) : '0;
	always_comb begin
		fin_free = free_q;
		fin_used = used_q;
		if (op_q == OP_RECOUNT) begin
			fin_used = (32'(acc_q) > 32'(CNT_MAX)) ? CNT_MAX : CNT_W'(acc_q);
			fin_free = (32'(rc_free) > 32'(CNT_MAX)) ? CNT_MAX : CNT_W'(rc_free);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			free_q <= '0;
			used_q <= '0;
			rsv_q <= RSV_RST;
			last_alloc_q <= '0;
			last_free_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + WAW'(1);
			if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			if (cmd.mod_wr) begin
				case (op_q)
					OP_ALLOC: begin
						free_q <= sat_dec(free_q, pc);
						used_q <= sat_inc(used_q, pc);
					end
					OP_FREE1, OP_FREER: begin
						free_q <= sat_inc(free_q, pc);
						used_q <= sat_dec(used_q, pc);
					end
					OP_RSV: rsv_q <= sat_inc(rsv_q, pc);
					OP_UNRSV: rsv_q <= sat_dec(rsv_q, pc);
					default: ;
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				free_q <= fin_free;
				used_q <= fin_used;
				if (op_q == OP_ALLOC && is_ok) last_alloc_q <= got;
				if ((op_q == OP_FREE1 || op_q == OP_FREER) && is_ok) last_free_q <= addr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && cin.valid) begin
			op_q <= cin.op;
			addr_q <= cin.byte_address;
			cnt_q <= cin.page_count;
			len_q <= cin.region_bytes;
		end
		if (cmd.prep) begin
			start_q <= WW'(addr_q >> SH);
			case (op_q)
				OP_FREE1: n_q <= WW'(1);
				OP_RSV: n_q <= WW'(((ADDR_W+1)'(len_q) + (ADDR_W+1)'(PAGE_BYTES - 1)) >> SH);
				OP_UNRSV: n_q <= WW'(len_q >> SH);
				default: n_q <= WW'(cnt_q);
			endcase
		end
		if (cmd.sum) end_q <= start_q + n_q;
		if (cmd.clamp) begin
			status_q <= st_c;
			lo_q <= lo_c;
			hi_q <= hi_c;
			w_q <= '0;
			sub_q <= '0;
			run_q <= '0;
			run_start_q <= '0;
			acc_q <= '0;
		end
		if (cmd.scan_bits) begin
			sub_q <= sub_q + 3'd1;
			run_q <= run_c;
			run_start_q <= rs_c;
			if (sub_q == 3'd7) w_q <= w_q + WAW'(1);
			if (hit_c) begin
				lo_q <= rs_c;
				hi_q <= re_c;
				status_q <= ST_OK;
			end
		end
		if (cmd.mark) w_q <= lo_w;
		if (cmd.mod_wr) begin
			w_q <= w_q + WAW'(1);
			if (op_q == OP_RECOUNT) acc_q <= acc_q + FW'(pc);
			if (op_q == OP_FREE1 && pc == '0) status_q <= ST_DFREE;
		end
		if (load_out) begin
			rsp.status <= status_q;
			rsp.alloc_address <= got;
			rsp.free_count <= fin_free;
			rsp.used_count <= fin_used;
			rsp.reserved_count <= rsv_q;
			rsp.last_alloc_address <= (op_q == OP_ALLOC && is_ok) ? got : last_alloc_q;
			rsp.last_free_address <=
				((op_q == OP_FREE1 || op_q == OP_FREER) && is_ok) ? addr_q : last_free_q;
		end
	end

	assign rsp.valid = out_valid_q;

	always_comb begin
		stat.in_fire = cmd.take && cin.valid;
		stat.clr_last = clr_q == WAW'(WORDS - 1);
		stat.go_scan = go_scan;
		stat.go_mod = go_mod;
		stat.scan_hit = hit_c;
		stat.sub_last = sub_q == 3'd7;
		stat.word_last = w_q == tm1[WAW+5:6];
		stat.mod_last = w_q == last_w;
		stat.out_busy = out_valid_q && !rsp.ready;
	end
endmodule
`default_nettype wire

// ===== src/bitmap_page_frame_allocator.sv =====
`default_nettype none
// channel | dir | payload
// cmd     | in  | op, byte_address, page_count, region_bytes
// rsp     | out | status, alloc_address, free/used/reserved counts, last addresses
// cfg     | in  | frames_in_use (write enable + data)
//
// Steps: alloc reads one 64-frame word per pass and walks it 8 frames a cycle,
//   then marks the run it found word by word, reading each word and writing it
//   back. Range ops also read and write back each 64-bit word touched; recount
//   only reads. Every item starts with setup (prep, sum, clamp) and ends at finish.
// Reset: a clearing pass writes all ones to all MAX_FRAMES/64 words before any item.
// Stalls: one item at a time; a result waits in the output register while the
//   next item is taken, and the block holds at finish only while that register is full and not read.
module bitmap_page_frame_allocator import bpfa_pkg::*; #(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	bpfa_cmd_if.sink cmd,
	bpfa_rsp_if.source rsp,
	input wire logic cfg_we,
	input wire logic [CNT_W-1:0] cfg_wdata
);
	cmd_t ctl;
	stat_t st;

	// sequencer: clear pass, setup, search, word update, finish
	bpfa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.stat(st),
		.cmd(ctl)
	);

	// bitmap memory, counters, range math and the result register
	bpfa_dp #(.MAX_FRAMES(MAX_FRAMES), .PAGE_BYTES(PAGE_BYTES)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(ctl),
		.stat(st),
		.cin(cmd),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);
endmodule
`default_nettype wire

// ===== bench/bpfa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Watches the command and response channels, keeps a shadow of the frame
// bitmap and counters, and compares every response with its prediction.
module bpfa_checker import bpfa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	bpfa_cmd_if cmd,
	bpfa_rsp_if rsp,
	input wire logic cfg_we,
	input wire logic [CNT_W-1:0] cfg_wdata,
	output int unsigned fail_count,
	output int unsigned pending
);
	localparam longint unsigned PAGE = PAGE_BYTES_DEF;
	localparam longint unsigned SAT_TOP = 131071;

	typedef struct {
		logic [ST_W-1:0] status;
		logic [ADDR_W-1:0] alloc_address;
		logic [CNT_W-1:0] free_count;
		logic [CNT_W-1:0] used_count;
		logic [CNT_W-1:0] reserved_count;
		logic [ADDR_W-1:0] last_alloc_address;
		logic [ADDR_W-1:0] last_free_address;
	} alloc_result_t;

	bit frame_used [MAX_FRAMES_DEF];
	logic [CNT_W-1:0] n_free, n_used, n_reserved;
	logic [ADDR_W-1:0] last_alloc, last_free;
	logic [CNT_W-1:0] frames_in_use;
	alloc_result_t expected_results [$];
	int unsigned errors;

	function automatic logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] c, longint unsigned n);
		longint unsigned s;
		s = longint'(c) + n;
		return (s > SAT_TOP) ? CNT_W'(SAT_TOP) : CNT_W'(s);
	endfunction

	function automatic logic [CNT_W-1:0] count_down(logic [CNT_W-1:0] c, longint unsigned n);
		return (longint'(c) > n) ? CNT_W'(longint'(c) - n) : '0;
	endfunction

	task automatic predict_command(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
		input logic [CNT_W-1:0] cnt, input logic [ADDR_W-1:0] len, output alloc_result_t r);
		longint unsigned total, i, f, run, start, n, stop;
		logic [ST_W-1:0] st;
		logic [ADDR_W-1:0] got;
		total = (frames_in_use > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : frames_in_use;
		st = ST_OK;
		got = '0;
		case (op)
			OP_ALLOC: begin
				if (cnt == 0) begin
					st = ST_INVAL;
				end else begin
					// first fit: lowest run of cnt free frames
					st = ST_OOM;
					run = 0;
					start = 0;
					for (i = 0; i < total; i++) begin
						if (frame_used[i]) begin
							run = 0;
						end else begin
							if (run == 0) start = i;
							run++;
							if (run == cnt) begin
								for (f = start; f <= i; f++) frame_used[f] = 1'b1;
								n_free = count_down(n_free, cnt);
								n_used = count_up(n_used, cnt);
								got = ADDR_W'(start * PAGE);
								last_alloc = got;
								st = ST_OK;
								break;
							end
						end
					end
				end
			end
			OP_FREE1: begin
				f = addr / PAGE;
				if (addr == 0 || addr % PAGE != 0) st = ST_INVAL;
				else if (f >= total) st = ST_OOB;
				else if (!frame_used[f]) st = ST_DFREE;
				else begin
					frame_used[f] = 1'b0;
					n_free = count_up(n_free, 1);
					n_used = count_down(n_used, 1);
					last_free = addr;
				end
			end
			OP_FREER: begin
				if (addr == 0 || cnt == 0 || addr % PAGE != 0) begin
					st = ST_INVAL;
				end else begin
					// frames already free are skipped without complaint
					start = addr / PAGE;
					stop = start + cnt;
					if (stop > total) stop = total;
					for (f = start; f < stop; f++) begin
						if (frame_used[f]) begin
							frame_used[f] = 1'b0;
							n_free = count_up(n_free, 1);
							n_used = count_down(n_used, 1);
						end
					end
					last_free = addr;
				end
			end
			OP_RSV, OP_UNRSV: begin
				// reserve rounds the length up, unreserve rounds it down
				start = addr / PAGE;
				n = (op == OP_RSV) ? (longint'(len) + PAGE - 1) / PAGE : len / PAGE;
				stop = start + n;
				if (stop > total) stop = total;
				for (f = start; f < stop; f++) begin
					if (op == OP_RSV && !frame_used[f]) begin
						frame_used[f] = 1'b1;
						n_reserved = count_up(n_reserved, 1);
					end else if (op == OP_UNRSV && frame_used[f]) begin
						frame_used[f] = 1'b0;
						n_reserved = count_down(n_reserved, 1);
					end
				end
			end
			OP_RECOUNT: begin
				n_free = '0;
				n_used = '0;
				for (i = 0; i < total; i++) begin
					if (frame_used[i]) n_used = count_up(n_used, 1);
					else n_free = count_up(n_free, 1);
				end
			end
			default: st = ST_INVAL;
		endcase
		r.status = st;
		r.alloc_address = got;
		r.free_count = n_free;
		r.used_count = n_used;
		r.reserved_count = n_reserved;
		r.last_alloc_address = last_alloc;
		r.last_free_address = last_free;
	endtask

	task automatic check_field(input string name, input longint unsigned exp_v,
		input longint unsigned act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t r;
		if (!arst_n) begin
			foreach (frame_used[i]) frame_used[i] = 1'b1;
			n_free = '0;
			n_used = '0;
			n_reserved = CNT_W'(MAX_FRAMES_DEF);
			last_alloc = '0;
			last_free = '0;
			frames_in_use = CNT_W'(65536);
			expected_results.delete();
			errors = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: response with no item outstanding, expected none, actual %0h",
						$time, rsp.status);
				end else begin
					r = expected_results.pop_front();
					check_field("status", r.status, rsp.status);
					check_field("alloc_address", r.alloc_address, rsp.alloc_address);
					check_field("free_count", r.free_count, rsp.free_count);
					check_field("used_count", r.used_count, rsp.used_count);
					check_field("reserved_count", r.reserved_count, rsp.reserved_count);
					check_field("last_alloc_address", r.last_alloc_address,
						rsp.last_alloc_address);
					check_field("last_free_address", r.last_free_address,
						rsp.last_free_address);
				end
			end
			if (cmd.valid && cmd.ready) begin
				predict_command(cmd.op, cmd.byte_address, cmd.page_count, cmd.region_bytes, r);
				expected_results.push_back(r);
			end
			if (cfg_we) frames_in_use = cfg_wdata;
		end
		fail_count <= errors;
		pending <= expected_results.size();
	end
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import bpfa_pkg::*;

	// opcodes the block must reject
	localparam logic [OP_W-1:0] OP_BAD_A = 3'd6;
	localparam logic [OP_W-1:0] OP_BAD_B = 3'd7;
	localparam longint unsigned PAGE = PAGE_BYTES_DEF;
	localparam int STALL_PCT = 23;
	// covers the worst alloc, a walk over all 1024 words, plus the clearing pass
	localparam int WATCHDOG_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;
	int unsigned fail_count, pending;
	int unsigned quiet_cycles;
	bit steady;          // when set, neither side idles
	int unsigned limit;  // frames_in_use currently programmed, capped at MAX

	bpfa_cmd_if cmd_ch();
	bpfa_rsp_if rsp_ch();

	always #1 clk = ~clk;

	bitmap_page_frame_allocator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	bpfa_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.pending(pending)
	);

	// response side back-pressure
	always @(posedge clk) begin
		rsp_ch.ready <= steady || ($urandom_range(99) >= STALL_PCT);
	end

	// nothing moving on either channel for too long means a hang
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	// One item. valid stays high from one item to the next unless a gap is drawn,
	// so there is a single assignment to valid in any time step.
	task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
		input logic [CNT_W-1:0] cnt, input logic [ADDR_W-1:0] len);
		if (!steady && $urandom_range(99) < STALL_PCT) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.op <= op;
		cmd_ch.byte_address <= addr;
		cmd_ch.page_count <= cnt;
		cmd_ch.region_bytes <= len;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	// register writes only with the block drained
	task automatic set_frames(input logic [CNT_W-1:0] v);
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit = (v > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : v;
	endtask

	function automatic logic [ADDR_W-1:0] rand_wide();
		return ADDR_W'({$urandom, $urandom});
	endfunction

	// mostly aligned addresses near the managed range, some wild or misaligned
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 8) return rand_wide();
		if (p < 13) return ADDR_W'($urandom_range(0, limit + 4) * PAGE + $urandom_range(1, 4095));
		return ADDR_W'($urandom_range(0, limit + 4) * PAGE);
	endfunction

	function automatic logic [CNT_W-1:0] pick_count();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 5) return '0;
		if (p < 13) return CNT_W'($urandom);
		if (p < 28) return CNT_W'($urandom_range(1, limit / 2 + 1));
		return CNT_W'($urandom_range(1, 8));
	endfunction

	function automatic logic [ADDR_W-1:0] pick_length();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 10) return rand_wide();
		if (p < 40) return ADDR_W'($urandom_range(0, 16) * PAGE + $urandom_range(0, 4095));
		return ADDR_W'($urandom_range(0, 24) * PAGE);
	endfunction

	// weighted toward alloc/free traffic; a few rejected opcodes
	task automatic random_cmd();
		int unsigned p;
		logic [OP_W-1:0] op;
		p = $urandom_range(99);
		if (p < 30) op = OP_ALLOC;
		else if (p < 50) op = OP_FREE1;
		else if (p < 62) op = OP_FREER;
		else if (p < 74) op = OP_RSV;
		else if (p < 88) op = OP_UNRSV;
		else if (p < 97) op = OP_RECOUNT;
		else op = p[0] ? OP_BAD_A : OP_BAD_B;
		send_cmd(op, pick_address(), pick_count(), pick_length());
	endtask

	initial begin
		logic [CNT_W-1:0] phase_frames [10];
		int unsigned phase_items [10];
		cmd_ch.valid = 1'b0;
		cmd_ch.op = OP_RECOUNT;
		cmd_ch.byte_address = '0;
		cmd_ch.page_count = '0;
		cmd_ch.region_bytes = '0;
		rsp_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		quiet_cycles = 0;
		steady = 1'b0;
		limit = MAX_FRAMES_DEF;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// straight out of reset everything is reserved: alloc fails on a full scan
		send_cmd(OP_ALLOC, '0, CNT_W'(1), '0);
		set_frames(CNT_W'(1024));
		send_cmd(OP_RECOUNT, '0, '0, '0);
		send_cmd(OP_ALLOC, '0, '0, '0);                          // zero pages
		send_cmd(OP_UNRSV, '0, '0, ADDR_W'(4095));               // rounds down to nothing
		send_cmd(OP_UNRSV, '0, '0, ADDR_W'(1024 * PAGE));
		send_cmd(OP_RECOUNT, '0, '0, '0);
		send_cmd(OP_ALLOC, '0, CNT_W'(1), '0);
		send_cmd(OP_ALLOC, '0, CNT_W'(3), '0);
		send_cmd(OP_ALLOC, '0, CNT_W'(65536), '0);               // no fit
		send_cmd(OP_ALLOC, '0, '1, '0);
		send_cmd(OP_FREE1, '0, '0, '0);                          // null
		send_cmd(OP_FREE1, ADDR_W'(PAGE + 1), '0, '0);           // misaligned
		send_cmd(OP_FREE1, ADDR_W'(1024 * PAGE), '0, '0);        // past the end
		send_cmd(OP_FREE1, ADDR_W'(PAGE), '0, '0);
		send_cmd(OP_FREE1, ADDR_W'(PAGE), '0, '0);               // double free
		send_cmd(OP_FREE1, '1, '0, '0);
		send_cmd(OP_FREE1, ADDR_W'(36'hFFFFFF000), '0, '0);
		send_cmd(OP_FREER, '0, CNT_W'(4), '0);
		send_cmd(OP_FREER, ADDR_W'(2 * PAGE), '0, '0);
		send_cmd(OP_FREER, ADDR_W'(2 * PAGE + 8), CNT_W'(4), '0);
		send_cmd(OP_FREER, ADDR_W'(2 * PAGE), CNT_W'(100), '0);  // mostly free already
		send_cmd(OP_FREER, ADDR_W'(1020 * PAGE), '1, '0);        // clipped at the end
		send_cmd(OP_RSV, ADDR_W'(10 * PAGE), '0, ADDR_W'(1));    // rounds up to a frame
		send_cmd(OP_RSV, ADDR_W'(20 * PAGE), '0, '0);
		send_cmd(OP_RSV, ADDR_W'(1000 * PAGE), '0, '1);
		send_cmd(OP_BAD_A, '1, '1, '1);
		send_cmd(OP_BAD_B, '0, '0, '0);
		send_cmd(OP_RECOUNT, '0, '0, '0);

		// random phases over several frame limits; the two largest stay short
		phase_frames = '{CNT_W'(0), CNT_W'(1), CNT_W'(64), CNT_W'(300), CNT_W'(1024),
			CNT_W'(777), CNT_W'(4096), CNT_W'(65536), CNT_W'(131071),
			CNT_W'($urandom_range(64, 2048))};
		phase_items = '{20, 20, 70, 70, 90, 70, 70, 8, 8, 100};
		for (int ph = 0; ph < 10; ph++) begin
			set_frames(phase_frames[ph]);
			steady = (ph == 4);
			// open up a random part of the space, then tally it
			send_cmd(OP_UNRSV, ADDR_W'($urandom_range(0, limit / 4) * PAGE), '0,
				ADDR_W'($urandom_range(limit / 2, limit + 2) * PAGE));
			send_cmd(OP_RECOUNT, '0, '0, '0);
			for (int k = 0; k < phase_items[ph]; k++) random_cmd();
		end
		steady = 1'b0;

		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== bitmap_page_frame_allocator.f =====
src/bpfa_pkg.sv
src/bpfa_if.sv
src/bpfa_ram.sv
src/bpfa_ctrl.sv
src/bpfa_dp.sv
src/bitmap_page_frame_allocator.sv
bench/bpfa_checker.sv
bench/tb.sv
